### rtl/core/tsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants for the timestamp gate: verdict codes, register
// indexes, reset values and the architectural state record.
// ----------------------------------------------------------------------------
package tsg_pkg;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT      = 3'd0,
    VERDICT_REJECT      = 3'd1,
    VERDICT_NEW_SESSION = 3'd2,
    VERDICT_POSE_SENT   = 3'd3,
    VERDICT_POSE_SKIP   = 3'd4,
    VERDICT_POSE_FAIL   = 3'd5
  } verdict_t;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_GAP   = 2'd0;
  localparam logic [1:0] CFG_MAX_GAP   = 2'd1;
  localparam logic [1:0] CFG_MAX_SKIPS = 2'd2;

  localparam logic signed [31:0] MIN_GAP_RST   = -32'sd1000;
  localparam logic [30:0]        MAX_GAP_RST   = 31'd1000000;
  localparam logic [7:0]         MAX_SKIPS_RST = 8'd10;

  localparam logic ACTION_GATE = 1'b0;
  localparam logic ACTION_POSE = 1'b1;

  typedef struct packed {
    logic        have_stamp;
    logic [31:0] last_stamp;
    logic        outlier_held;
    logic [31:0] outlier_stamp;
    logic [31:0] session_count;
    logic [31:0] pose_session;
    logic        pose_latched;
    logic [7:0]  pose_skip_run;
    logic [31:0] last_pose_stamp;
    logic [31:0] accept_total;
    logic [31:0] gate_total;
    logic [31:0] skip_total;
  } tsg_state_t;

endpackage

### rtl/core/tsg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_step
// Next-state logic for one beat: gates a received stamp or qualifies an
// outgoing pose stamp, and returns the verdict and the updated state.
// ----------------------------------------------------------------------------
module tsg_step
  import tsg_pkg::*;
(
  input  tsg_state_t         st_i,
  input  logic signed [31:0] min_gap_i,
  input  logic [30:0]        max_gap_i,
  input  logic [7:0]         max_skips_i,
  input  logic               action_i,
  input  logic [31:0]        stamp_i,
  input  logic               send_ok_i,
  output tsg_state_t         st_o,
  output verdict_t           verdict_o
);

  logic [31:0]        gap;
  logic [31:0]        out_gap;
  logic [31:0]        pose_gap;
  logic signed [32:0] gap_x;
  logic signed [32:0] out_gap_x;
  logic signed [32:0] hi_x;
  logic               in_window;
  logic               outlier_ok;
  logic               latched_eff;
  logic               not_after;
  logic [7:0]         run_inc;

  assign gap      = stamp_i - st_i.last_stamp;
  assign out_gap  = stamp_i - st_i.outlier_stamp;
  assign pose_gap = stamp_i - st_i.last_pose_stamp;
  assign gap_x     = {gap[31], gap};
  assign out_gap_x = {out_gap[31], out_gap};
  assign hi_x      = $signed({2'b00, max_gap_i});

  assign in_window  = ($signed(gap) >= min_gap_i) && (gap_x <= hi_x);
  // held outlier confirmed by a stamp 0..max_gap after it
  assign outlier_ok = st_i.outlier_held && !out_gap[31] && (out_gap_x <= hi_x);

  // a session change forgets the pose reference
  assign latched_eff = (st_i.session_count != st_i.pose_session) ? 1'b0 : st_i.pose_latched;
  assign not_after   = pose_gap[31] || (pose_gap == 32'd0);
  assign run_inc     = st_i.pose_skip_run + 8'd1;

  always_comb begin
    st_o      = st_i;
    verdict_o = VERDICT_ACCEPT;
    if (action_i == ACTION_GATE) begin
      if (!st_i.have_stamp) begin
        st_o.have_stamp = 1'b1;
        st_o.last_stamp = stamp_i;
        verdict_o       = VERDICT_ACCEPT;
      end else if (in_window) begin
        if (!gap[31] && (gap != 32'd0)) begin
          st_o.last_stamp = stamp_i;
        end
        st_o.outlier_held = 1'b0;
        verdict_o         = VERDICT_ACCEPT;
      end else if (outlier_ok) begin
        st_o.last_stamp    = stamp_i;
        st_o.outlier_held  = 1'b0;
        st_o.session_count = st_i.session_count + 32'd1;
        verdict_o          = VERDICT_NEW_SESSION;
      end else begin
        st_o.outlier_stamp = stamp_i;
        st_o.outlier_held  = 1'b1;
        verdict_o          = VERDICT_REJECT;
      end
      if (verdict_o == VERDICT_REJECT) begin
        st_o.gate_total = st_i.gate_total + 32'd1;
      end else begin
        st_o.accept_total = st_i.accept_total + 32'd1;
      end
    end else begin
      st_o.pose_session = st_i.session_count;
      st_o.pose_latched = latched_eff;
      if (latched_eff && not_after && (run_inc < max_skips_i)) begin
        st_o.skip_total    = st_i.skip_total + 32'd1;
        st_o.pose_skip_run = run_inc;
        verdict_o          = VERDICT_POSE_SKIP;
      end else begin
        if (latched_eff && not_after) begin
          // skip limit hit: count it, drop the reference, send anyway
          st_o.skip_total   = st_i.skip_total + 32'd1;
          st_o.pose_latched = 1'b0;
        end
        st_o.pose_skip_run = 8'd0;
        if (!send_ok_i) begin
          verdict_o = VERDICT_POSE_FAIL;
        end else begin
          st_o.last_pose_stamp = stamp_i;
          st_o.pose_latched    = 1'b1;
          verdict_o            = VERDICT_POSE_SENT;
        end
      end
    end
  end

endmodule

### rtl/core/timestamp_gate_with_reboot_adopt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_gate_with_reboot_adopt
// Remote timestamp gate with reboot adoption and pose-stamp qualifier.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; one beat per cycle sustained
//   while out_stall does not hold the result register, set by the combinational
//   state update in tsg_step between those two registers.
// Reset (rst_n low, synchronous): all gate/pose state and counters clear,
//   config registers return to min_gap -1000, max_gap 1000000, skips 10.
// Config writes are always taken (cfg_ready tied high).
module timestamp_gate_with_reboot_adopt
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_stamp_us,
  input  logic        in_send_ok,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_session_id,
  output logic [31:0] out_newest_tick,
  output logic        out_time_known,
  output logic [31:0] out_accepted_count,
  output logic [31:0] out_gated_count,
  output logic [31:0] out_skipped_count,
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // config registers
  logic signed [31:0] min_gap_r;
  logic [30:0]        max_gap_r;
  logic [7:0]         max_skips_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_action_r;
  logic [31:0] s1_stamp_r;
  logic        s1_send_ok_r;

  // architectural state; it only moves when a result enters the output
  // register, so the result fields read straight from it
  tsg_state_t st_r, st_nxt;

  // result register
  logic     out_valid_r, out_valid_nxt;
  verdict_t verdict_r, verdict_nxt;

  logic out_free;   // result register can take a beat this cycle
  logic advance;    // input register moves into the result register
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  tsg_step u_step (
    .st_i       (st_r),
    .min_gap_i  (min_gap_r),
    .max_gap_i  (max_gap_r),
    .max_skips_i(max_skips_r),
    .action_i   (s1_action_r),
    .stamp_i    (s1_stamp_r),
    .send_ok_i  (s1_send_ok_r),
    .st_o       (st_nxt),
    .verdict_o  (verdict_nxt)
  );

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // config write decode; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r   <= MIN_GAP_RST;
      max_gap_r   <= MAX_GAP_RST;
      max_skips_r <= MAX_SKIPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_GAP:   min_gap_r   <= $signed(cfg_data);
        CFG_MAX_GAP:   max_gap_r   <= cfg_data[30:0];
        CFG_MAX_SKIPS: max_skips_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r  <= in_action;
      s1_stamp_r   <= in_stamp_us;
      s1_send_ok_r <= in_send_ok;
    end
    if (advance) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_session_id     = st_r.session_count;
  assign out_newest_tick    = st_r.last_stamp;
  assign out_time_known     = st_r.have_stamp;
  assign out_accepted_count = st_r.accept_total;
  assign out_gated_count    = st_r.gate_total;
  assign out_skipped_count  = st_r.skip_total;

  // state holds while no beat moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !advance) |=> $stable(st_r))
    else $error("state changed without a beat");

  // session count only moves on an adopted reboot
  a_session_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (st_nxt.session_count != st_r.session_count))
      |-> (verdict_nxt == VERDICT_NEW_SESSION))
    else $error("session bump without new-session verdict");

  // once time is known it stays known
  a_time_known: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && st_r.have_stamp) |=> st_r.have_stamp)
    else $error("time_known dropped");

endmodule

### dv/tb_timestamp_gate_with_reboot_adopt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_gate_with_reboot_adopt
// Self-checking bench for the timestamp gate. A queue-fed driver sends
// received and pose stamps. A monitor checks every result beat against an
// in-bench predictor of the gate, the reboot adoption and the pose skip
// logic. The run goes through several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_timestamp_gate_with_reboot_adopt;
  import tsg_pkg::*;

  localparam int RUN_LIMIT   = 400000;  // cycles; slowest legal run is far below
  localparam int SHOW_LIMIT  = 10;      // mismatches printed in full
  localparam int DRAIN_WAIT  = 8;       // cycles to wait after the last result

  // one input beat
  typedef struct packed {
    logic        action;
    logic [31:0] stamp;
    logic        send_ok;
  } stamp_beat_t;

  // one result beat, in port order
  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] session;
    logic [31:0] tick;
    logic        known;
    logic [31:0] n_accept;
    logic [31:0] n_gated;
    logic [31:0] n_skip;
  } gate_report_t;

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        in_action   = ACTION_GATE;
  logic [31:0] in_stamp_us = '0;
  logic        in_send_ok  = 1'b0;

  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [2:0]  out_verdict;
  logic [31:0] out_session_id;
  logic [31:0] out_newest_tick;
  logic        out_time_known;
  logic [31:0] out_accepted_count;
  logic [31:0] out_gated_count;
  logic [31:0] out_skipped_count;

  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index   = CFG_MIN_GAP;
  logic [31:0] cfg_data    = '0;

  timestamp_gate_with_reboot_adopt dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_stamp_us        (in_stamp_us),
    .in_send_ok         (in_send_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_session_id     (out_session_id),
    .out_newest_tick    (out_newest_tick),
    .out_time_known     (out_time_known),
    .out_accepted_count (out_accepted_count),
    .out_gated_count    (out_gated_count),
    .out_skipped_count  (out_skipped_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // --------------------------------------------------------------------------
  // predictor state: a private copy of the gate, kept in step with the
  // beats the DUT actually accepts
  // --------------------------------------------------------------------------
  logic signed [31:0] gate_min   = MIN_GAP_RST;
  logic [30:0]        gate_max   = MAX_GAP_RST;
  logic [7:0]         pose_limit = MAX_SKIPS_RST;

  logic        have_time     = 1'b0;
  logic [31:0] newest        = '0;
  logic        outlier_valid = 1'b0;
  logic [31:0] outlier_val   = '0;
  logic [31:0] session_n     = '0;
  logic [31:0] pose_sess     = '0;
  logic        pose_armed    = 1'b0;
  logic [7:0]  skip_run      = '0;
  logic [31:0] pose_prev     = '0;
  logic [31:0] n_accept      = '0;
  logic [31:0] n_gated       = '0;
  logic [31:0] n_skip        = '0;

  stamp_beat_t  stamp_q[$];     // beats waiting for the driver
  gate_report_t outcome_q[$];   // predicted results, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int errors        = 0;
  int beats_in      = 0;
  int cycle_count   = 0;
  int verdict_seen[0:7];

  // remote and pose clocks used only to shape stimulus
  logic [31:0] remote_clk = '0;
  logic [31:0] pose_clk   = '0;

  // Gate / pose decision for one accepted beat. Updates the private state and
  // returns the result the DUT has to produce.
  function automatic gate_report_t qualify(input logic action, input logic [31:0] stamp,
                                           input logic ok);
    gate_report_t       r;
    logic signed [31:0] gap;
    logic signed [31:0] pgap;
    logic signed [31:0] hi;
    logic               skipped;
    hi      = $signed({1'b0, gate_max});
    skipped = 1'b0;
    r       = '0;
    if (action == ACTION_GATE) begin
      gap  = stamp - newest;
      pgap = stamp - outlier_val;
      if (!have_time) begin
        // first stamp: taken as is, outlier flag untouched
        have_time = 1'b1;
        newest    = stamp;
        r.verdict = VERDICT_ACCEPT;
      end else if (gap >= gate_min && gap <= hi) begin
        if (gap > 0) newest = stamp;    // only moves forward
        outlier_valid = 1'b0;
        r.verdict     = VERDICT_ACCEPT;
      end else if (outlier_valid && pgap >= 0 && pgap <= hi) begin
        // second stamp agrees with the held outlier: remote clock rebooted
        newest        = stamp;
        outlier_valid = 1'b0;
        session_n     = session_n + 32'd1;
        r.verdict     = VERDICT_NEW_SESSION;
      end else begin
        outlier_val   = stamp;
        outlier_valid = 1'b1;
        r.verdict     = VERDICT_REJECT;
      end
      if (r.verdict == VERDICT_REJECT) n_gated = n_gated + 32'd1;
      else n_accept = n_accept + 32'd1;
    end else begin
      // a new session invalidates the pose reference, skip run survives
      if (session_n != pose_sess) begin
        pose_sess  = session_n;
        pose_armed = 1'b0;
      end
      gap = stamp - pose_prev;
      if (pose_armed && gap <= 0) begin
        n_skip   = n_skip + 32'd1;
        skip_run = skip_run + 8'd1;
        if (skip_run < pose_limit) begin
          skipped   = 1'b1;
          r.verdict = VERDICT_POSE_SKIP;
        end else begin
          pose_armed = 1'b0;            // limit hit: drop reference, send anyway
        end
      end
      if (!skipped) begin
        skip_run = '0;
        if (!ok) begin
          r.verdict = VERDICT_POSE_FAIL;
        end else begin
          pose_prev  = stamp;
          pose_armed = 1'b1;
          r.verdict  = VERDICT_POSE_SENT;
        end
      end
    end
    r.session  = session_n;
    r.tick     = newest;
    r.known    = have_time;
    r.n_accept = n_accept;
    r.n_gated  = n_gated;
    r.n_skip   = n_skip;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driver: one beat per cycle at most, payload held while stalled
  // --------------------------------------------------------------------------
  stamp_beat_t drive_beat;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(qualify(in_action, in_stamp_us, in_send_ok));
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (stamp_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_beat = stamp_q.pop_front();
          in_valid    <= 1'b1;
          in_action   <= drive_beat.action;
          in_stamp_us <= drive_beat.stamp;
          in_send_ok  <= drive_beat.send_ok;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure, compare each taken result beat
  // --------------------------------------------------------------------------
  gate_report_t want;
  gate_report_t got;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        verdict_seen[out_verdict]++;
        got.verdict  = verdict_t'(out_verdict);
        got.session  = out_session_id;
        got.tick     = out_newest_tick;
        got.known    = out_time_known;
        got.n_accept = out_accepted_count;
        got.n_gated  = out_gated_count;
        got.n_skip   = out_skipped_count;
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("%0t: result beat with nothing expected (verdict %0d)",
                     $realtime, out_verdict);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= SHOW_LIMIT) begin
              $display("%0t: mismatch (exp/act) verdict %0d/%0d session %h/%h tick %h/%h",
                       $realtime, want.verdict, got.verdict, want.session, got.session,
                       want.tick, got.tick);
              $display("  known %0d/%0d accepted %0d/%0d gated %0d/%0d skipped %0d/%0d",
                       want.known, got.known, want.n_accept, got.n_accept,
                       want.n_gated, got.n_gated, want.n_skip, got.n_skip);
            end
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Run stopped at the cycle limit, %0d results still pending", outcome_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_beat(input logic action, input logic [31:0] stamp, input logic ok);
    stamp_beat_t b;
    b.action  = action;
    b.stamp   = stamp;
    b.send_ok = ok;
    stamp_q.push_back(b);
  endtask

  // everything sent and every result back
  task automatic wait_drained();
    do @(negedge clk);
    while (stamp_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_GAP:   gate_min   = $signed(data);
      CFG_MAX_GAP:   gate_max   = data[30:0];
      CFG_MAX_SKIPS: pose_limit = data[7:0];
      default: ;
    endcase
  endtask

  // Mostly well-formed traffic: in-window stamps riding a remote clock, reboot
  // pairs, pose stamps that wobble around the last one sent; some noise.
  task automatic push_random_beats(input int n);
    longint lo;
    longint hi;
    longint a;
    longint b;
    longint gap;
    int     pick;
    lo = longint'(gate_min);
    hi = longint'(gate_max);
    a  = (lo > -50) ? lo : -50;
    b  = (hi < 5000) ? hi : 5000;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        if ($urandom_range(0, 1)) pose_clk = pose_clk + $urandom_range(1, 5);
        else pose_clk = pose_clk - $urandom_range(0, 3);
        add_beat(ACTION_POSE, pose_clk, $urandom_range(0, 9) != 0);
      end else if (pick < 70) begin
        case ($urandom_range(0, 9))
          0:       gap = 0;
          1:       gap = hi;
          2:       gap = lo;
          3:       gap = hi + 1;            // just outside the window
          4:       gap = lo - 1;
          default: gap = a + $urandom_range(0, int'(b - a));
        endcase
        add_beat(ACTION_GATE, remote_clk + 32'(gap), 1'($urandom_range(0, 1)));
        if (gap > 0 && gap <= hi) remote_clk = remote_clk + 32'(gap);
      end else if (pick < 85) begin
        // remote reboot: a jump, then a stamp just after it
        remote_clk = $urandom();
        add_beat(ACTION_GATE, remote_clk, 1'b0);
        remote_clk = remote_clk + $urandom_range(0, (hi < 300) ? int'(hi) : 300);
        add_beat(ACTION_GATE, remote_clk, 1'b1);
      end else begin
        add_beat(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic set_idle_mix(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 77; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 77; end
      default: begin send_idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  // One register setting: drain, reprogram, queue equal pose stamps, then random traffic in bursts.
  // Now and then the sender holds off until every result is back.
  task automatic run_phase(input logic [31:0] min_gap, input logic [31:0] max_gap,
                           input logic [31:0] skips, input int mode, input int n);
    int left;
    int burst;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(CFG_MIN_GAP, min_gap);
    write_reg(CFG_MAX_GAP, max_gap);
    write_reg(CFG_MAX_SKIPS, skips);
    set_idle_mix(mode);
    @(negedge clk);
    remote_clk = newest;
    pose_clk   = pose_prev;
    // a run of identical pose stamps walks the skip counter up toward the limit
    repeat (4) add_beat(ACTION_POSE, pose_clk, 1'b1);
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      push_random_beats(burst);
      left -= burst;
      if ($urandom_range(0, 3) == 0) wait_drained();
      else do @(negedge clk); while (stamp_q.size() != 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] back_edge;
    logic [31:0] fwd_edge;
    logic [31:0] far_stamp;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    add_beat(ACTION_POSE, 32'h0000_0000, 1'b1);   // pose with no stamp yet: sent
    add_beat(ACTION_POSE, 32'h0000_0000, 1'b1);   // equal stamp: skipped
    add_beat(ACTION_POSE, 32'hFFFF_FFFF, 1'b0);   // wrapped older: skipped
    add_beat(ACTION_POSE, 32'h0000_0001, 1'b0);   // newer but link refuses
    add_beat(ACTION_GATE, 32'hFFFF_FFF0, 1'b1);   // first stamp, send_ok ignored
    add_beat(ACTION_GATE, 32'h0000_0010, 1'b0);   // forward across the wrap
    add_beat(ACTION_GATE, 32'h0000_0010, 1'b1);   // zero gap: accepted, no move
    add_beat(ACTION_GATE, 32'h0000_0010 - 32'd1000, 1'b0);  // lower window edge
    back_edge = 32'h0000_0010 - 32'd1001;
    add_beat(ACTION_GATE, back_edge, 1'b0);       // just below: held as outlier
    add_beat(ACTION_GATE, back_edge, 1'b0);       // same again: new session
    fwd_edge = back_edge + 32'd1000000;
    add_beat(ACTION_GATE, fwd_edge, 1'b0);        // upper window edge
    add_beat(ACTION_GATE, fwd_edge + 32'd1000001, 1'b0);   // one past it
    far_stamp = fwd_edge + 32'h8000_0000;
    add_beat(ACTION_GATE, far_stamp, 1'b0);       // most negative gap, new outlier
    add_beat(ACTION_GATE, far_stamp + 32'd1000000, 1'b0);  // confirms it at max
    add_beat(ACTION_POSE, 32'd5, 1'b1);           // session moved: reference dropped
    add_beat(ACTION_POSE, 32'd4, 1'b1);
    add_beat(ACTION_POSE, 32'h8000_0005, 1'b1);   // half-range ahead counts as behind
    add_beat(ACTION_POSE, 32'd6, 1'b0);
    add_beat(ACTION_POSE, 32'd7, 1'b1);
    add_beat(ACTION_GATE, 32'hFFFF_FFFF, 1'b1);
    add_beat(ACTION_GATE, 32'h0000_0000, 1'b1);
    add_beat(ACTION_GATE, 32'h0000_0000, 1'b0);

    // random phases across register settings, extremes first
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd255, 1, 76);
    run_phase(32'd0, 32'd0, 32'd1, 2, 76);
    run_phase(-32'sd1000, 32'd1000000, 32'd0, 3, 76);
    run_phase(32'd0 - $urandom_range(0, 5000), $urandom_range(1, 20000), 32'd2, 0, 76);
    run_phase(-32'sd50, 32'd100, 32'd3, 1, 76);
    run_phase(32'd0 - $urandom_range(0, 32'h8000_0000), $urandom_range(0, 32'h7FFF_FFFF),
              $urandom_range(1, 255), 2, 76);
    run_phase(-32'sd1000, 32'd1000000, 32'd10, 3, 76);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    errors += outcome_q.size();

    $display("Checked %0d beats over 8 register settings and four idle/stall mixes.",
             beats_in);
    $display("Verdicts: accept %0d reject %0d new session %0d sent %0d skip %0d fail %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2],
             verdict_seen[3], verdict_seen[4], verdict_seen[5]);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
